>>> sv/pee_pkg.sv
// ============================================================================
// Postfix evaluator package
// Shared types, symbol codes and status codes of the postfix evaluator.
// ============================================================================
package pee_pkg;

    // ASCII codes of the recognized expression characters.
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Reported status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_DIVZERO   = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_START,
        S_WAIT,
        S_FINISH
    } seq_state_t;

    typedef enum logic [1:0] {
        A_IDLE,
        A_MUL,
        A_DIV,
        A_FIN
    } alu_state_t;

    // Input beat.
    typedef struct packed {
        logic [7:0] symbol;
        logic       last_symbol;
    } in_t;

    // Output beat.
    typedef struct packed {
        logic signed [15:0] value;
        logic [2:0]         status;
    } out_t;

    // Request from the sequencer to the arithmetic unit.
    typedef struct packed {
        logic start;
        op_t  op;
    } alu_ctrl_t;

    // Status returned by the arithmetic unit.
    typedef struct packed {
        logic    busy;
        logic    done;
        status_t code;
    } alu_stat_t;

endpackage

>>> sv/pee_stack.sv
// ============================================================================
// Operand stack memory
// Single write port, single registered read port storage for stack entries.
// ============================================================================
module pee_stack #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic signed [31:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic signed [31:0] rd_data
);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/pee_alu.sv
// ============================================================================
// Iterative arithmetic unit
// One shared 33-bit adder performs add, subtract, shift-add multiply and
// restoring divide on signed fixed-point operands, with saturation.
// ============================================================================
module pee_alu #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pee_pkg::alu_ctrl_t   ctrl,
    input  logic signed [31:0]   lhs,
    input  logic signed [31:0]   rhs,
    output pee_pkg::alu_stat_t   stat,
    output logic signed [31:0]   result
);
    import pee_pkg::*;

    localparam int QW   = 32 + FRAC_BITS;
    localparam int CNTW = $clog2(QW + 1);

    alu_state_t        state_reg, state_next;
    logic [CNTW-1:0]   cnt_reg, cnt_next;
    op_t               op_reg, op_next;
    logic              dz_reg, dz_next;
    logic              neg_reg, neg_next;
    logic [63:0]       acc_reg, acc_next;
    logic [31:0]       rem_reg, rem_next;
    logic [31:0]       opnd_reg, opnd_next;

    logic [31:0]       mag_l, mag_r;
    logic [32:0]       add_a, add_b;
    logic              add_sub;
    logic [33:0]       add_sum;
    logic [63:0]       res_mag;
    logic              ovf;

    assign mag_l = lhs[31] ? 32'd0 - 32'(lhs) : 32'(lhs);
    assign mag_r = rhs[31] ? 32'd0 - 32'(rhs) : 32'(rhs);

    // Shared adder; subtraction adds the inverted operand plus one.
    assign add_sum = {1'b0, add_a} + {1'b0, add_b ^ {33{add_sub}}} + 34'(add_sub);

    always_comb
    begin
        add_a   = {lhs[31], lhs};
        add_b   = {rhs[31], rhs};
        add_sub = (ctrl.op == OP_SUB);
        case (state_reg)
            A_MUL:
            begin
                add_a   = {1'b0, acc_reg[63:32]};
                add_b   = acc_reg[0] ? {1'b0, opnd_reg} : 33'd0;
                add_sub = 1'b0;
            end
            A_DIV:
            begin
                add_a   = {rem_reg, acc_reg[QW-1]};
                add_b   = {1'b0, opnd_reg};
                add_sub = 1'b1;
            end
            default:
            begin
                add_a   = {lhs[31], lhs};
                add_b   = {rhs[31], rhs};
                add_sub = (ctrl.op == OP_SUB);
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg) inside
            A_IDLE:
            begin
                if (ctrl.start)
                begin
                    case (ctrl.op)
                        OP_MUL:  state_next = A_MUL;
                        OP_DIV:  state_next = (rhs == 32'sd0) ? A_FIN : A_DIV;
                        default: state_next = A_FIN;
                    endcase
                end
            end
            A_MUL, A_DIV:
            begin
                if (cnt_reg == CNTW'(1))
                begin
                    state_next = A_FIN;
                end
            end
            A_FIN:   state_next = A_IDLE;
            default: state_next = A_IDLE;
        endcase
    end

    // Datapath updates.
    always_comb
    begin
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        dz_next   = dz_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        opnd_next = opnd_reg;
        unique case (state_reg)
            A_IDLE:
            begin
                if (ctrl.start)
                begin
                    op_next   = ctrl.op;
                    dz_next   = (ctrl.op == OP_DIV) && (rhs == 32'sd0);
                    neg_next  = lhs[31] ^ rhs[31];
                    opnd_next = mag_r;
                    rem_next  = 32'd0;
                    case (ctrl.op)
                        OP_MUL:
                        begin
                            acc_next = {32'd0, mag_l};
                            cnt_next = CNTW'(32);
                        end
                        OP_DIV:
                        begin
                            // Divide by zero saturates on the sign of the left operand.
                            if (rhs == 32'sd0)
                            begin
                                neg_next = lhs[31];
                            end
                            acc_next = 64'({mag_l, {FRAC_BITS{1'b0}}});
                            cnt_next = CNTW'(QW);
                        end
                        default:
                        begin
                            acc_next = 64'(add_sum[32:0]);
                        end
                    endcase
                end
            end
            A_MUL:
            begin
                acc_next = {add_sum[32:0], acc_reg[31:1]};
                cnt_next = cnt_reg - CNTW'(1);
            end
            A_DIV:
            begin
                rem_next = add_sum[33] ? add_sum[31:0] : add_a[31:0];
                acc_next = 64'({acc_reg[QW-2:0], add_sum[33]});
                cnt_next = cnt_reg - CNTW'(1);
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Result formation and saturation in the final cycle.
    always_comb
    begin
        res_mag     = (op_reg == OP_MUL) ? (acc_reg >> FRAC_BITS) : acc_reg;
        ovf         = 1'b0;
        result      = 32'sd0;
        stat.code   = ST_OK;
        case (op_reg) inside
            OP_ADD, OP_SUB:
            begin
                ovf = acc_reg[32] != acc_reg[31];
                if (ovf)
                begin
                    result    = acc_reg[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    stat.code = ST_OVERFLOW;
                end
                else
                begin
                    result = $signed(acc_reg[31:0]);
                end
            end
            default:
            begin
                if (dz_reg)
                begin
                    result    = neg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    stat.code = ST_DIVZERO;
                end
                else if (neg_reg)
                begin
                    ovf = (|res_mag[63:32]) || (res_mag[31] && (|res_mag[30:0]));
                    if (ovf)
                    begin
                        result    = 32'sh8000_0000;
                        stat.code = ST_OVERFLOW;
                    end
                    else
                    begin
                        result = $signed(32'd0 - res_mag[31:0]);
                    end
                end
                else
                begin
                    ovf = |res_mag[63:31];
                    if (ovf)
                    begin
                        result    = 32'sh7FFF_FFFF;
                        stat.code = ST_OVERFLOW;
                    end
                    else
                    begin
                        result = $signed(res_mag[31:0]);
                    end
                end
            end
        endcase
        stat.done = (state_reg == A_FIN);
        stat.busy = (state_reg != A_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        dz_reg   <= dz_next;
        neg_reg  <= neg_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        opnd_reg <= opnd_next;
    end

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> state_reg == A_IDLE)
        else $error("operation started while the unit was busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |=> !stat.done)
        else $error("done held for more than one cycle");

    a_iter_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == A_MUL || state_reg == A_DIV) |-> cnt_reg != '0)
        else $error("iteration counter ran out during an operation");

endmodule

>>> sv/postfix_expression_evaluator_core.sv
// ============================================================================
// Postfix expression evaluator
// Evaluates reverse Polish expressions on signed fixed point, one character
// per input beat, and reports the integer part of the final stack top.
// ============================================================================
// Usage: each input beat carries one character and a flag marking the last
// character of an expression. The block is ready for the next beat only when
// the previous character is fully processed. A digit is pushed in a decode
// state; an operator with two stacked entries reads the entry below the top
// there, starts the shared iterative adder and waits for it to finish, which
// for a multiply or divide works one multiplier bit or one quotient bit per
// cycle. The last character then passes a finish state that loads the output
// beat and clears the stack and the sticky status for the next expression.
// Characters other than digits and the four operators change nothing.
// The output beat sits in a register: the block keeps taking characters while
// a result waits, and only the next last character stalls until the receiver
// takes the held beat. Reset empties the stack, clears the status and drops
// any pending output beat; stack memory contents are not cleared.
// ============================================================================
module postfix_expression_evaluator_core #(
    parameter int STACK_DEPTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  pee_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output pee_pkg::out_t  out_data
);
    import pee_pkg::*;

    // Address bits for the stack and count bits that can hold a full stack.
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    seq_state_t         state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    status_t            sticky_reg, sticky_next;
    logic [7:0]         sym_reg, sym_next;
    logic               last_reg, last_next;
    logic signed [31:0] top_reg, top_next;
    logic               out_valid_reg, out_valid_next;
    out_t               out_data_reg, out_data_next;

    // Stack memory port.
    logic               mem_wr_en;
    logic [AW-1:0]      mem_wr_addr;
    logic signed [31:0] mem_wr_data;
    logic               mem_rd_en;
    logic [AW-1:0]      mem_rd_addr;
    logic signed [31:0] mem_rd_data;

    // Arithmetic unit.
    alu_ctrl_t          alu_ctrl;
    alu_stat_t          alu_stat;
    logic signed [31:0] alu_result;

    // Symbol decode.
    logic               is_digit;
    logic               is_op;
    op_t                sym_op;
    logic               can_pop;
    logic [7:0]         digit_off;
    logic signed [31:0] digit_val;

    // Final integer conversion of the stack top.
    logic               top_neg;
    logic [31:0]        top_mag;
    logic [31:0]        int_q;
    logic               fin_sat;
    logic signed [15:0] fin_value;
    status_t            fin_code;
    status_t            fin_status;
    logic               out_free;

    // The top of stack lives in top_reg as well as in memory, so an operator
    // needs only one memory read for the entry below it.
    pee_stack #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    pee_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (alu_ctrl),
        .lhs    (mem_rd_data),
        .rhs    (top_reg),
        .stat   (alu_stat),
        .result (alu_result)
    );

    // Decode of the held character.
    always_comb
    begin
        is_digit  = (sym_reg >= CH_0) && (sym_reg <= CH_9);
        digit_off = sym_reg - CH_0;
        digit_val = $signed(32'({28'd0, digit_off[3:0]}) << FRAC_BITS);
        is_op     = 1'b1;
        sym_op    = OP_ADD;
        case (sym_reg)
            CH_PLUS:  sym_op = OP_ADD;
            CH_MINUS: sym_op = OP_SUB;
            CH_STAR:  sym_op = OP_MUL;
            CH_SLASH: sym_op = OP_DIV;
            default:  is_op  = 1'b0;
        endcase
        can_pop = (count_reg >= CW'(2));
    end

    // The final integer is the magnitude shifted down, saturated to 16 bits.
    // A most negative stack top has magnitude 2^31, which still fits 32 bits.
    always_comb
    begin
        top_neg   = top_reg[31];
        top_mag   = top_neg ? 32'd0 - 32'(top_reg) : 32'(top_reg);
        int_q     = top_mag >> FRAC_BITS;
        fin_sat   = top_neg ? (int_q > 32'd32768) : (int_q > 32'd32767);
        fin_value = 16'sd0;
        fin_code  = ST_OK;
        if (count_reg == '0)
        begin
            fin_code = ST_EMPTY;
        end
        else if (fin_sat)
        begin
            fin_value = top_neg ? 16'sh8000 : 16'sh7FFF;
            fin_code  = ST_OVERFLOW;
        end
        else
        begin
            fin_value = top_neg ? $signed(16'd0 - int_q[15:0]) : $signed(int_q[15:0]);
        end
        // Only the first error of an expression is reported.
        fin_status = (sticky_reg == ST_OK) ? fin_code : sticky_reg;
        out_free   = !out_valid_reg || out_ready;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (is_op && can_pop)
                begin
                    state_next = S_START;
                end
                else
                begin
                    state_next = last_reg ? S_FINISH : S_IDLE;
                end
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (alu_stat.done)
                begin
                    state_next = last_reg ? S_FINISH : S_IDLE;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs and datapath.
    always_comb
    begin
        count_next     = count_reg;
        sticky_next    = sticky_reg;
        sym_next       = sym_reg;
        last_next      = last_reg;
        top_next       = top_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        in_ready       = 1'b0;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = count_reg[AW-1:0];
        mem_wr_data    = digit_val;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = AW'(count_reg - CW'(2));
        alu_ctrl.start = 1'b0;
        alu_ctrl.op    = sym_op;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    sym_next  = in_data.symbol;
                    last_next = in_data.last_symbol;
                end
            end
            S_DECODE:
            begin
                if (is_digit)
                begin
                    if (count_reg == CW'(STACK_DEPTH))
                    begin
                        if (sticky_reg == ST_OK)
                        begin
                            sticky_next = ST_FULL;
                        end
                    end
                    else
                    begin
                        mem_wr_en  = 1'b1;
                        top_next   = digit_val;
                        count_next = count_reg + CW'(1);
                    end
                end
                else if (is_op)
                begin
                    if (can_pop)
                    begin
                        mem_rd_en = 1'b1;
                    end
                    else if (sticky_reg == ST_OK)
                    begin
                        sticky_next = ST_UNDERFLOW;
                    end
                end
            end
            S_START:
            begin
                alu_ctrl.start = 1'b1;
            end
            S_WAIT:
            begin
                if (alu_stat.done)
                begin
                    // The result replaces the left operand and becomes the top.
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = AW'(count_reg - CW'(2));
                    mem_wr_data = alu_result;
                    top_next    = alu_result;
                    count_next  = count_reg - CW'(1);
                    if (sticky_reg == ST_OK)
                    begin
                        sticky_next = alu_stat.code;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_data_next.value  = fin_value;
                    out_data_next.status = fin_status;
                    count_next           = '0;
                    sticky_next          = ST_OK;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            sticky_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sticky_reg    <= sticky_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg      <= sym_next;
        last_reg     <= last_next;
        top_reg      <= top_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The stack never holds more entries than it has room for.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count exceeds the stack depth");

    // Between expression ends the count moves by at most one entry a cycle.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_FINISH) |=> (count_reg == $past(count_reg)
            || count_reg == $past(count_reg) + CW'(1)
            || count_reg == $past(count_reg) - CW'(1)))
        else $error("stack count jumped outside an expression end");

    // Loading a result clears the stack and status and raises valid.
    a_finish_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_free) |=>
            (count_reg == '0 && sticky_reg == ST_OK && out_valid_reg))
        else $error("expression end did not clear the evaluator");

    // The arithmetic unit is idle whenever a new character can be taken.
    a_alu_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !alu_stat.busy)
        else $error("arithmetic unit busy while accepting a character");

endmodule
